FILE: rtl/ssl_pkg.sv
// Shared types and constants for the session slot table.
`default_nettype none

package ssl_pkg;

  localparam int ADDR_W    = 48;
  localparam int SESS_W    = 32;
  localparam int TICK_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  localparam logic [TICK_W-1:0] LOCKOUT_TICKS_RST = 16'd5000;
  localparam logic [SESS_W-1:0] FIRST_SESSION_RST = 32'd1;

  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT_TICKS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_SESSION = 2'd1;

  typedef enum logic [2:0] {
    OP_RECORD    = 3'd0,
    OP_LOST      = 3'd1,
    OP_HEARTBEAT = 3'd2,
    OP_FORCE     = 3'd3,
    OP_TICK      = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ACT_APPENDED        = 3'd0,
    ACT_OPENED          = 3'd1,
    ACT_CLOSED_LOST     = 3'd2,
    ACT_CLOSED_FORCED   = 3'd3,
    ACT_REFUSED_LOCKOUT = 3'd4,
    ACT_REFUSED_FULL    = 3'd5,
    ACT_LOST_UNKNOWN    = 3'd6,
    ACT_NONE_OPEN       = 3'd7
  } act_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  // write command into the slot store
  typedef struct packed {
    logic set;
    logic clr;
  } slot_cmd_t;

  // status of the slot under the scan index, and whether any other slot or any slot is open
  typedef struct packed {
    logic open;
    logic match;
    logic open_others;
    logic any_open;
  } slot_stat_t;

  typedef struct packed {
    act_t              action;
    logic [2:0]        slot_index;
    logic [SESS_W-1:0] session;
    logic [ADDR_W-1:0] addr;
    logic              active;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/ssl_slot_store.sv
// Slot store: open flags, addresses, session numbers and the shared address comparator.
`default_nettype none

module ssl_slot_store import ssl_pkg::*; #(
  parameter int NUM_SLOTS = 8,
  parameter int IDX_W     = 3
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [IDX_W-1:0]  rd_idx,
  input  wire logic [IDX_W-1:0]  wr_idx,
  input  wire slot_cmd_t         cmd,
  input  wire logic [ADDR_W-1:0] key,
  input  wire logic [SESS_W-1:0] wr_session,
  output slot_stat_t             stat,
  output logic      [ADDR_W-1:0] rd_addr,
  output logic      [SESS_W-1:0] rd_session
);

  logic [NUM_SLOTS-1:0] slot_open;
  logic [ADDR_W-1:0]    slot_address [NUM_SLOTS];
  logic [SESS_W-1:0]    slot_session [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] rd_mask;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_open <= '0;
    end else if (cmd.set) begin
      slot_open[wr_idx] <= 1'b1;
    end else if (cmd.clr) begin
      slot_open[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set) begin
      slot_address[wr_idx] <= key;
      slot_session[wr_idx] <= wr_session;
    end
  end

  assign rd_addr    = slot_address[rd_idx];
  assign rd_session = slot_session[rd_idx];
  assign rd_mask    = NUM_SLOTS'(1) << rd_idx;

  always_comb begin
    stat.open        = slot_open[rd_idx];
    stat.match       = slot_open[rd_idx] && (rd_addr == key);
    stat.open_others = |(slot_open & ~rd_mask);
    stat.any_open    = |slot_open;
  end

endmodule

`default_nettype wire

FILE: rtl/ssl_ctrl.sv
// Sequencer: walks the slots one per cycle while results find room, keeps counters and config registers.
`default_nettype none

module ssl_ctrl import ssl_pkg::*; #(
  parameter int NUM_SLOTS = 8,
  parameter int IDX_W     = 3
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           operation,
  input  wire logic [ADDR_W-1:0]    device_address,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  input  wire slot_stat_t           stat,
  input  wire logic [ADDR_W-1:0]    rd_addr,
  input  wire logic [SESS_W-1:0]    rd_session,
  output logic      [IDX_W-1:0]     rd_idx,
  output logic      [IDX_W-1:0]     wr_idx,
  output slot_cmd_t                 cmd,
  output logic      [ADDR_W-1:0]    key,
  output logic      [SESS_W-1:0]    wr_session,
  input  wire logic                 res_room,
  output logic                      res_push,
  output result_t                   res
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SLOTS - 1);

  state_t            state, state_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic              free_found, free_found_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  logic              emitted, emitted_next;
  logic [TICK_W-1:0] lockout_remaining, lockout_remaining_next;
  logic [TICK_W-1:0] lockout_ticks, lockout_ticks_next;
  logic [SESS_W-1:0] next_session, next_session_next;
  op_t               op_q;
  logic [ADDR_W-1:0] addr_q;
  logic              is_last;
  logic              free_here;
  logic              finish;

  assign rd_idx     = idx;
  assign key        = addr_q;
  assign wr_session = next_session;
  assign is_last    = (idx == LAST_IDX);
  assign free_here  = free_found || !stat.open;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      idx               <= '0;
      free_found        <= 1'b0;
      free_idx          <= '0;
      emitted           <= 1'b0;
      lockout_remaining <= '0;
      lockout_ticks     <= LOCKOUT_TICKS_RST;
      next_session      <= FIRST_SESSION_RST;
    end else begin
      state             <= state_next;
      idx               <= idx_next;
      free_found        <= free_found_next;
      free_idx          <= free_idx_next;
      emitted           <= emitted_next;
      lockout_remaining <= lockout_remaining_next;
      lockout_ticks     <= lockout_ticks_next;
      next_session      <= next_session_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_q   <= op_t'(operation);
      addr_q <= device_address;
    end
  end

  always_comb begin
    state_next             = state;
    idx_next               = idx;
    free_found_next        = free_found;
    free_idx_next          = free_idx;
    emitted_next           = emitted;
    lockout_remaining_next = lockout_remaining;
    lockout_ticks_next     = lockout_ticks;
    next_session_next      = next_session;
    in_ready               = 1'b0;
    wr_idx                 = idx;
    cmd                    = '0;
    res_push               = 1'b0;
    finish                 = 1'b0;
    res.action             = ACT_NONE_OPEN;
    res.slot_index         = 3'(idx);
    res.session            = rd_session;
    res.addr               = rd_addr;
    res.active             = stat.any_open;
    res.last               = 1'b1;

    if (cfg_valid) begin
      unique case (cfg_index)
        REG_LOCKOUT_TICKS: lockout_ticks_next = cfg_data[TICK_W-1:0];
        REG_FIRST_SESSION: next_session_next  = cfg_data[SESS_W-1:0];
        default: ;
      endcase
    end

    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (op_t'(operation))
            OP_RECORD, OP_LOST, OP_FORCE: begin
              state_next      = ST_SCAN;
              idx_next        = '0;
              free_found_next = 1'b0;
              emitted_next    = 1'b0;
            end
            OP_TICK: begin
              if (lockout_remaining != '0) begin
                lockout_remaining_next = lockout_remaining - TICK_W'(1);
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        case (op_q)
          OP_RECORD: begin
            if (stat.match) begin
              res.action = ACT_APPENDED;
              res.active = 1'b1;
              res_push   = res_room;
              finish     = res_room;
            end else if (!is_last) begin
              if (!stat.open && !free_found) begin
                free_found_next = 1'b1;
                free_idx_next   = idx;
              end
              idx_next = idx + IDX_W'(1);
            end else begin
              res.slot_index = '0;
              res.session    = '0;
              res.addr       = addr_q;
              if (lockout_remaining != '0) begin
                res.action = ACT_REFUSED_LOCKOUT;
              end else if (free_here) begin
                wr_idx         = free_found ? free_idx : idx;
                res.action     = ACT_OPENED;
                res.slot_index = 3'(wr_idx);
                res.session    = next_session;
                res.active     = 1'b1;
                cmd.set        = res_room;
                if (res_room) begin
                  next_session_next = next_session + SESS_W'(1);
                end
              end else begin
                res.action = ACT_REFUSED_FULL;
              end
              res_push = res_room;
              finish   = res_room;
            end
          end

          OP_LOST: begin
            if (stat.match) begin
              res.action = ACT_CLOSED_LOST;
              res.active = stat.open_others;
              cmd.clr    = res_room;
              res_push   = res_room;
              finish     = res_room;
            end else if (is_last) begin
              res.action     = ACT_LOST_UNKNOWN;
              res.slot_index = '0;
              res.session    = '0;
              res.addr       = addr_q;
              res_push       = res_room;
              finish         = res_room;
            end else begin
              idx_next = idx + IDX_W'(1);
            end
          end

          OP_FORCE: begin
            if (stat.open) begin
              // slots below were already closed, so nothing open above means last beat
              res.action = ACT_CLOSED_FORCED;
              res.active = 1'b0;
              res.last   = !stat.open_others;
              cmd.clr    = res_room;
              res_push   = res_room;
              if (res_room) begin
                emitted_next = 1'b1;
                if (is_last) begin
                  finish = 1'b1;
                end else begin
                  idx_next = idx + IDX_W'(1);
                end
              end
            end else if (!is_last) begin
              idx_next = idx + IDX_W'(1);
            end else if (emitted) begin
              finish = 1'b1;
            end else begin
              res.action     = ACT_NONE_OPEN;
              res.slot_index = '0;
              res.session    = '0;
              res.addr       = '0;
              res.active     = 1'b0;
              res_push       = res_room;
              finish         = res_room;
            end
            if (finish) begin
              lockout_remaining_next = lockout_ticks;
            end
          end

          default: finish = 1'b1;
        endcase

        if (finish) begin
          state_next = ST_IDLE;
        end
      end

      default: state_next = ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/session_slot_table_top.sv
// Top level of the session slot table: sequencer, slot store and output register.
// Record and lost: after the accept, the sequencer steps the single address comparator over
// the slots in order, at most NUM_SLOTS, stopping at a match. Heartbeat, tick: no scan.
// Force stop: scans all slots; a result beat per open slot, or one none-open beat if none.
// Result beats wait in one output register; the scan stalls while it is full.
// Synchronous reset: all slots closed, lockout zero, next session 1, lockout ticks 5000.
`default_nettype none

module session_slot_table_top import ssl_pkg::*; #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [2:0]           operation,
  input  wire logic [ADDR_W-1:0]    device_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic      [2:0]           action,
  output logic      [2:0]           slot_index,
  output logic      [SESS_W-1:0]    session_number,
  output logic      [ADDR_W-1:0]    address_echo,
  output logic                      tracking_active,
  output logic                      last,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data
);

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  slot_stat_t        stat;
  slot_cmd_t         cmd;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  wr_idx;
  logic [ADDR_W-1:0] key;
  logic [SESS_W-1:0] wr_session;
  logic [ADDR_W-1:0] rd_addr;
  logic [SESS_W-1:0] rd_session;
  logic              res_room;
  logic              res_push;
  result_t           res;
  result_t           out_q;

  assign cfg_ready = 1'b1;
  assign res_room  = !out_valid || out_ready;

  ssl_ctrl #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .device_address(device_address),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .stat          (stat),
    .rd_addr       (rd_addr),
    .rd_session    (rd_session),
    .rd_idx        (rd_idx),
    .wr_idx        (wr_idx),
    .cmd           (cmd),
    .key           (key),
    .wr_session    (wr_session),
    .res_room      (res_room),
    .res_push      (res_push),
    .res           (res)
  );

  ssl_slot_store #(
    .NUM_SLOTS(NUM_SLOTS),
    .IDX_W    (IDX_W)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_idx    (rd_idx),
    .wr_idx    (wr_idx),
    .cmd       (cmd),
    .key       (key),
    .wr_session(wr_session),
    .stat      (stat),
    .rd_addr   (rd_addr),
    .rd_session(rd_session)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_q <= res;
    end
  end

  assign action          = out_q.action;
  assign slot_index      = out_q.slot_index;
  assign session_number  = out_q.session;
  assign address_echo    = out_q.addr;
  assign tracking_active = out_q.active;
  assign last            = out_q.last;

endmodule

`default_nettype wire
